### sv/rrip_dead_block_ship_stream_replacement_assert.svh
// assertion macros for the replacement policy block
// used by modules that check their own control logic, expects clk and rst_n in scope
`ifndef RRIP_DEAD_BLOCK_SHIP_STREAM_REPLACEMENT_ASSERT_SVH
`define RRIP_DEAD_BLOCK_SHIP_STREAM_REPLACEMENT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define RDB_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rdb check failed");

// antecedent implies consequent in the next cycle
`define RDB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rdb check failed");

`endif

### sv/rdb_pkg.sv
// shared types and constants for the replacement policy block
// no dependencies
`timescale 1ns / 1ps
package rdb_pkg;
    localparam int ADDR_W      = 48;
    localparam int SET_W       = 11;
    localparam int WAY_W       = 4;
    localparam int SCORE_W     = 3;
    localparam int PERIOD_W    = 21;
    localparam int COUNT_W     = 20;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 21;
    localparam int STRIDE      = 64;
    localparam int LINE_SHIFT  = 6;
    localparam logic signed [SCORE_W-1:0] SCORE_MIN = -3'sd4;
    localparam logic signed [SCORE_W-1:0] SCORE_MAX = 3'sd3;
    localparam logic signed [SCORE_W-1:0] THR_RESET = 3'sd2;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 21'd16384;
    localparam logic [PERIOD_W-1:0] PERIOD_MAX   = 21'd1048576;
    localparam logic [1:0] RRPV_RESET = 2'd2;
    localparam logic [1:0] DEAD_RESET = 2'd1;
    localparam logic [1:0] SIG_RESET  = 2'd1;
    localparam logic [1:0] CTR_MAX    = 2'd3;
    localparam logic [1:0] RRPV_FAR   = 2'd3;
    localparam logic [1:0] RRPV_LONG  = 2'd2;
    localparam logic [1:0] RRPV_NEAR  = 2'd0;
    localparam logic [1:0] STRONG_MIN = 2'd2;

    typedef enum logic {ACT_QUERY = 1'b0, ACT_UPDATE = 1'b1} action_t;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STREAM_THRESHOLD = 1'b0,
        CFG_SWEEP_INTERVAL   = 1'b1
    } cfg_idx_t;
    typedef enum logic [2:0] {ST_CLEAR, ST_IDLE, ST_EXEC, ST_SIGWR, ST_SWEEP} state_t;

    typedef struct packed {
        logic wr;
        logic clr;
        logic inc;
    } sig_op_t;
endpackage

### sv/rdb_if.sv
// word channels for the replacement policy block
// depends on rdb_pkg
`timescale 1ns / 1ps
interface rdb_req_if;
    import rdb_pkg::*;
    logic                valid;
    logic                ready;
    logic                action;
    logic [SET_W-1:0]    set_index;
    logic [WAY_W-1:0]    way_index;
    logic [ADDR_W-1:0]   phys_addr;
    logic [ADDR_W-1:0]   prog_counter;
    logic                was_hit;
    modport source (output valid, action, set_index, way_index, phys_addr, prog_counter,
                    was_hit, input ready);
    modport sink (input valid, action, set_index, way_index, phys_addr, prog_counter,
                  was_hit, output ready);
endinterface

interface rdb_rsp_if;
    import rdb_pkg::*;
    logic             valid;
    logic             ready;
    logic [WAY_W-1:0] victim_way;
    modport source (output valid, victim_way, input ready);
    modport sink (input valid, victim_way, output ready);
endinterface

### sv/rdb_ram.sv
// simple dual port synchronous memory, one write and one registered read
// no dependencies
`timescale 1ns / 1ps
module rdb_ram #(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 32
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

### sv/rdb_sig_table.sv
// signature outcome table memory, saturating 2-bit counters updated read-modify-write
// depends on rdb_pkg
`timescale 1ns / 1ps
module rdb_sig_table #(
    parameter int HASH_W = 6
) (
    input  logic              clk,
    input  rdb_pkg::sig_op_t  op,
    input  logic              re,
    input  logic [HASH_W-1:0] raddr,
    input  logic [HASH_W-1:0] waddr,
    output logic [1:0]        rdata
);
    import rdb_pkg::*;
    localparam int ENT = 1 << HASH_W;

    logic [1:0] mem [ENT];
    logic [1:0] wdata;

    // non-clear write data comes from the entry read in the previous cycle
    always_comb
    begin
        if (op.clr)
        begin
            wdata = SIG_RESET;
        end
        else if (op.inc)
        begin
            wdata = (rdata != CTR_MAX) ? rdata + 2'd1 : CTR_MAX;
        end
        else
        begin
            wdata = (rdata != 2'd0) ? rdata - 2'd1 : 2'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op.wr)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

### sv/rrip_dead_block_ship_stream_replacement.sv
// channel   dir  word
// req       in   action, set_index, way_index, phys_addr, prog_counter, was_hit
// rsp       out  victim_way (victim queries only)
// cfg       in   cfg_we / cfg_index / cfg_data register writes
// a query: set row read in the accept cycle, modify and write back in the next
// an update with an in-range way also writes back the signature table entry in ST_SIGWR
// set rows with stream history and the signature table live in two rams with registered reads
// after reset a clearing pass over all set rows and signature entries runs first
// a decay sweep after every sweep-interval updates walks both rams, decrementing their counters
// a waiting result holds off intake of the next item until it is taken
// top level: depends on rdb_pkg, rdb_if, rdb_ram, rdb_sig_table and the assert header
`timescale 1ns / 1ps
`include "rrip_dead_block_ship_stream_replacement_assert.svh"
module rrip_dead_block_ship_stream_replacement #(
    parameter int NUM_SETS       = 2048,
    parameter int NUM_WAYS       = 16,
    parameter int SIGNATURE_BITS = 6
) (
    input  logic                           clk,
    input  logic                           rst_n,
    rdb_req_if.sink                        req,
    rdb_rsp_if.source                      rsp,
    input  logic                           cfg_we,
    input  logic [rdb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rdb_pkg::CFG_DATA_W-1:0] cfg_data
);
    import rdb_pkg::*;

    localparam int SB      = SIGNATURE_BITS;
    localparam int ENT     = 1 << SB;
    localparam int SWEEP_N = NUM_SETS > ENT ? NUM_SETS : ENT;
    localparam int AW      = NUM_SETS > 1 ? $clog2(NUM_SETS) : 1;
    localparam int SW      = $clog2(SWEEP_N + 1);
    localparam int WW      = $clog2(NUM_WAYS);
    localparam int STW     = SCORE_W + ADDR_W;
    localparam int RW      = NUM_WAYS * (4 + SB) + STW;
    localparam int RSH     = 24;
    localparam longint RECIP = ((longint'(1) << RSH) + NUM_SETS - 1) / NUM_SETS;

    state_t state_reg, state_next;
    logic [SW-1:0] cnt_reg, cnt_next;
    logic                      act_reg;
    logic [AW-1:0]             set_reg;
    logic [WAY_W-1:0]          way_reg;
    logic [ADDR_W-1:0]         addr_reg;
    logic [ADDR_W-1:0]         pc_reg;
    logic                      hit_reg;
    logic                      out_v_reg, out_v_next;
    logic [WAY_W-1:0]          out_way_reg;
    logic signed [SCORE_W-1:0] thr_reg;
    logic [PERIOD_W-1:0]       period_reg;
    logic [COUNT_W-1:0]        count_reg, count_next;
    logic                      decay_reg, decay_next;

    logic          accept;
    logic [AW-1:0] set_red;

    logic          row_we, row_re;
    logic [AW-1:0] row_waddr, row_raddr;
    logic [RW-1:0] row_wdata, row_rdata;
    logic [STW-1:0] str_wdata, str_rdata;

    logic [NUM_WAYS-1:0][1:0]    rrpv_rd, dead_rd, rrpv_wr, dead_wr, aged, dead_dec;
    logic [NUM_WAYS-1:0][SB-1:0] sig_rd, sig_wr;

    logic [WW-1:0]  vic_dead, vic_rrpv, way_sel;
    logic           dead_found;
    logic [1:0]     top;
    logic           way_ok, upd_go;
    logic [ADDR_W-1:0] prev;
    logic signed [SCORE_W-1:0] score, score_new;
    logic           step_up, streaming;
    logic [SB-1:0]  sig, old_sig, tgt, sig_in;
    logic [1:0]     dead_upd, dead_eff, rrpv_new;
    logic [PERIOD_W-1:0] period_eff, cnt_inc;
    logic           do_decay, sig_hot;
    logic           sig_re;
    logic [SB-1:0]  sig_raddr, sig_waddr;
    logic [1:0]     sig_rdata, sig_adj, sig_dec;
    sig_op_t        sig_op;

    // set index reduced into range
    generate
        if (NUM_SETS >= (1 << SET_W))
        begin : g_set_direct
            assign set_red = AW'(req.set_index);
        end
        else
        begin : g_set_mod
            logic [SET_W+RSH:0]   prod;
            logic [SET_W-1:0]     quo;
            logic signed [SET_W+1:0] rem;
            always_comb
            begin
                prod = (SET_W+RSH+1)'(req.set_index) * (SET_W+RSH+1)'(RECIP);
                quo  = SET_W'(prod >> RSH);
                rem  = $signed({2'b00, req.set_index})
                     - $signed((SET_W+2)'(quo) * (SET_W+2)'(NUM_SETS));
                if (rem < 0)
                begin
                    rem = rem + (SET_W+2)'(NUM_SETS);
                end
            end
            assign set_red = AW'(rem);
        end
    endgenerate

    assign req.ready = (state_reg == ST_IDLE) && (!out_v_reg || rsp.ready);
    assign accept    = req.valid && req.ready;
    assign rsp.valid      = out_v_reg;
    assign rsp.victim_way = out_way_reg;
    assign sig_in = req.prog_counter[SB-1:0] ^ req.phys_addr[SB+LINE_SHIFT-1:LINE_SHIFT];

    rdb_ram #(.DEPTH(NUM_SETS), .WIDTH(RW)) u_row_ram (
        .clk   (clk),
        .we    (row_we),
        .waddr (row_waddr),
        .wdata (row_wdata),
        .re    (row_re),
        .raddr (row_raddr),
        .rdata (row_rdata)
    );

    rdb_sig_table #(.HASH_W(SB)) u_sig_table (
        .clk   (clk),
        .op    (sig_op),
        .re    (sig_re),
        .raddr (sig_raddr),
        .waddr (sig_waddr),
        .rdata (sig_rdata)
    );

    assign {str_rdata, sig_rd, dead_rd, rrpv_rd} = row_rdata;

    // victim search
    always_comb
    begin
        vic_dead   = '0;
        vic_rrpv   = '0;
        dead_found = 1'b0;
        top        = 2'd0;
        for (int w = NUM_WAYS - 1; w >= 0; w--)
        begin
            if (dead_rd[w] == 2'd0)
            begin
                vic_dead   = WW'(w);
                dead_found = 1'b1;
            end
        end
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            if (rrpv_rd[w] > top)
            begin
                top = rrpv_rd[w];
            end
        end
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            aged[w]     = rrpv_rd[w] + (RRPV_FAR - top);
            dead_dec[w] = (dead_rd[w] != 2'd0) ? dead_rd[w] - 2'd1 : 2'd0;
        end
        for (int w = NUM_WAYS - 1; w >= 0; w--)
        begin
            if (aged[w] == RRPV_FAR)
            begin
                vic_rrpv = WW'(w);
            end
        end
    end

    // update path
    always_comb
    begin
        way_ok  = ({1'b0, way_reg} < (WAY_W+1)'(NUM_WAYS));
        way_sel = WW'(way_reg);
        upd_go  = (state_reg == ST_EXEC) && (act_reg == ACT_UPDATE) && way_ok;
        prev    = str_rdata[ADDR_W-1:0];
        score   = $signed(str_rdata[STW-1:ADDR_W]);
        step_up = ({1'b0, addr_reg} == ({1'b0, prev} + (ADDR_W+1)'(STRIDE)))
               || ({1'b0, prev} == ({1'b0, addr_reg} + (ADDR_W+1)'(STRIDE)));
        score_new = score;
        if (step_up)
        begin
            if (score < SCORE_MAX)
            begin
                score_new = score + 3'sd1;
            end
        end
        else if (addr_reg != prev)
        begin
            if (score > SCORE_MIN)
            begin
                score_new = score - 3'sd1;
            end
        end
        streaming = (score_new >= thr_reg);
        sig       = pc_reg[SB-1:0] ^ addr_reg[SB+LINE_SHIFT-1:LINE_SHIFT];
        old_sig   = sig_rd[way_sel];
        tgt       = hit_reg ? sig : old_sig;
        if (hit_reg)
        begin
            dead_upd = (dead_rd[way_sel] != CTR_MAX) ? dead_rd[way_sel] + 2'd1 : CTR_MAX;
        end
        else
        begin
            dead_upd = (dead_rd[way_sel] != 2'd0) ? dead_rd[way_sel] - 2'd1 : 2'd0;
        end
        if (period_reg == '0)
        begin
            period_eff = PERIOD_W'(1);
        end
        else if (period_reg > PERIOD_MAX)
        begin
            period_eff = PERIOD_MAX;
        end
        else
        begin
            period_eff = period_reg;
        end
        cnt_inc  = {1'b0, count_reg} + PERIOD_W'(1);
        do_decay = (cnt_inc >= period_eff);
        dead_eff = (do_decay && dead_upd != 2'd0) ? dead_upd - 2'd1 : dead_upd;
        // table entry of the new signature as it stands after this update
        if (hit_reg)
        begin
            sig_adj = (sig_rdata != CTR_MAX) ? sig_rdata + 2'd1 : CTR_MAX;
        end
        else if ((old_sig == sig) && (sig_rdata != 2'd0))
        begin
            sig_adj = sig_rdata - 2'd1;
        end
        else
        begin
            sig_adj = sig_rdata;
        end
        sig_dec = (do_decay && sig_adj != 2'd0) ? sig_adj - 2'd1 : sig_adj;
        sig_hot = (sig_dec >= STRONG_MIN);
        if (streaming)
        begin
            rrpv_new = ((pc_reg[0] ^ addr_reg[0]) && !hit_reg) ? RRPV_FAR : RRPV_LONG;
        end
        else if ((dead_eff == 2'd0) && !hit_reg)
        begin
            rrpv_new = RRPV_FAR;
        end
        else if (sig_hot)
        begin
            rrpv_new = RRPV_NEAR;
        end
        else
        begin
            rrpv_new = RRPV_LONG;
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        count_next = count_reg;
        out_v_next = out_v_reg;
        decay_next = decay_reg;
        row_we     = 1'b0;
        row_re     = accept;
        row_raddr  = set_red;
        row_waddr  = set_reg;
        rrpv_wr    = rrpv_rd;
        dead_wr    = dead_rd;
        sig_wr     = sig_rd;
        str_wdata  = str_rdata;
        sig_re     = accept;
        sig_raddr  = sig_in;
        sig_waddr  = tgt;
        sig_op     = '0;
        if (rsp.valid && rsp.ready)
        begin
            out_v_next = 1'b0;
        end
        case (state_reg)
            ST_CLEAR:
            begin
                row_we     = (cnt_reg < SW'(NUM_SETS));
                row_waddr  = AW'(cnt_reg);
                rrpv_wr    = {NUM_WAYS{RRPV_RESET}};
                dead_wr    = {NUM_WAYS{DEAD_RESET}};
                sig_wr     = '0;
                str_wdata  = '0;
                sig_op.wr  = (cnt_reg < SW'(ENT));
                sig_op.clr = 1'b1;
                sig_waddr  = SB'(cnt_reg);
                cnt_next   = cnt_reg + SW'(1);
                if (cnt_reg == SW'(SWEEP_N - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
                if (act_reg == ACT_QUERY)
                begin
                    out_v_next = 1'b1;
                    row_we     = !dead_found;
                    rrpv_wr    = aged;
                end
                else if (way_ok)
                begin
                    row_we           = 1'b1;
                    rrpv_wr[way_sel] = rrpv_new;
                    dead_wr[way_sel] = dead_upd;
                    sig_wr[way_sel]  = sig;
                    str_wdata        = {score_new, addr_reg};
                    sig_re           = 1'b1;
                    sig_raddr        = tgt;
                    count_next       = COUNT_W'(cnt_inc);
                    decay_next       = do_decay;
                    state_next       = ST_SIGWR;
                    if (do_decay)
                    begin
                        count_next = '0;
                        cnt_next   = '0;
                    end
                end
            end
            ST_SIGWR:
            begin
                sig_op.wr  = 1'b1;
                sig_op.inc = hit_reg;
                state_next = decay_reg ? ST_SWEEP : ST_IDLE;
            end
            ST_SWEEP:
            begin
                row_re    = (cnt_reg < SW'(NUM_SETS));
                row_raddr = AW'(cnt_reg);
                row_we    = (cnt_reg != '0) && (cnt_reg <= SW'(NUM_SETS));
                row_waddr = AW'(cnt_reg - SW'(1));
                dead_wr   = dead_dec;
                sig_re    = (cnt_reg < SW'(ENT));
                sig_raddr = SB'(cnt_reg);
                sig_op.wr = (cnt_reg != '0) && (cnt_reg <= SW'(ENT));
                sig_waddr = SB'(cnt_reg - SW'(1));
                cnt_next  = cnt_reg + SW'(1);
                if (cnt_reg == SW'(SWEEP_N))
                begin
                    cnt_next   = '0;
                    decay_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        row_wdata = {str_wdata, sig_wr, dead_wr, rrpv_wr};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            cnt_reg    <= '0;
            count_reg  <= '0;
            out_v_reg  <= 1'b0;
            decay_reg  <= 1'b0;
            thr_reg    <= THR_RESET;
            period_reg <= PERIOD_RESET;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            count_reg <= count_next;
            out_v_reg <= out_v_next;
            decay_reg <= decay_next;
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_STREAM_THRESHOLD: thr_reg    <= $signed(cfg_data[SCORE_W-1:0]);
                    CFG_SWEEP_INTERVAL:   period_reg <= cfg_data[PERIOD_W-1:0];
                    default:              thr_reg    <= thr_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg  <= req.action;
            set_reg  <= set_red;
            way_reg  <= req.way_index;
            addr_reg <= req.phys_addr;
            pc_reg   <= req.prog_counter;
            hit_reg  <= req.was_hit;
        end
        if ((state_reg == ST_EXEC) && (act_reg == ACT_QUERY))
        begin
            out_way_reg <= WAY_W'(dead_found ? vic_dead : vic_rrpv);
        end
    end

    `RDB_ASSERT_SAME(a_ready_idle, req.ready, state_reg == ST_IDLE)
    `RDB_ASSERT_NEXT(a_exec_once, state_reg == ST_EXEC, state_reg != ST_EXEC)
    `RDB_ASSERT_NEXT(a_sigwr_once, state_reg == ST_SIGWR, state_reg != ST_SIGWR)
    `RDB_ASSERT_SAME(a_sweep_bound, state_reg == ST_SWEEP, cnt_reg <= SW'(SWEEP_N))
    `RDB_ASSERT_NEXT(a_query_result, (state_reg == ST_EXEC) && (act_reg == ACT_QUERY), rsp.valid)
endmodule
